[src/ide_pkg.sv]
// Types and constants shared by the deque engine modules.
// No dependencies.
package ide_pkg;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned REQ_W = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W = 9;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK = 3'd1,
      REQ_POP_FRONT = 3'd2,
      REQ_POP_BACK = 3'd3,
      REQ_SEARCH = 3'd4,
      REQ_MID_INSERT = 3'd5,
      REQ_MAX = 3'd6,
      REQ_NONE = 3'd7
   } req_type_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 3'd0,
      ST_EMPTY = 3'd1,
      ST_FULL = 3'd2,
      ST_PRESENT = 3'd3,
      ST_SHORT = 3'd4
   } status_type;

   // Per-cycle command broadcast from the control to every cell.
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;
endpackage

[src/ide_cell.sv]
// One list entry of the deque engine: holds a value, shifts with its neighbors.
// Depends on ide_pkg.
module ide_cell (
   input  logic                        clock,
   input  ide_pkg::cell_cmd_type       cmd,
   input  logic                        sel_ins,
   input  logic                        up_en,
   input  logic                        dn_en,
   input  logic                        live,
   input  logic [ide_pkg::DATA_W-1:0]  lower_val,
   input  logic [ide_pkg::DATA_W-1:0]  upper_val,
   input  logic [ide_pkg::DATA_W-1:0]  max_in,
   output logic [ide_pkg::DATA_W-1:0]  val,
   output logic                        match,
   output logic [ide_pkg::DATA_W-1:0]  max_out
);
   import ide_pkg::*;
   logic [DATA_W-1:0] val_ff, val_in, max_ff, max_nx;

   always_comb begin
      val_in = val_ff;
      if (cmd.shift_up && sel_ins) val_in = cmd.value;
      else if (cmd.shift_up && up_en) val_in = lower_val;
      else if (cmd.shift_down && dn_en) val_in = upper_val;
      max_nx = (live && $signed(val_ff) > $signed(max_in)) ? val_ff : max_in;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      max_ff <= max_nx;
   end

   assign val = val_ff;
   assign match = live && (val_ff == cmd.value);
   assign max_out = max_ff;
endmodule

[src/integer_deque_engine.sv]
// Top level of the deque engine: control sequencer plus a row of ide_cell.
// Depends on ide_pkg and ide_cell.
//
// Usage: drive req_type and req_operand_value with start high; the request is
// taken when busy is low. busy rises the next cycle. One result per request
// appears on rsp_* for exactly one cycle with rsp_valid high.
// Push, pop, search and middle insert go from transfer to result through
// S_CMP, which compares the operand in every cell, S_EVAL, which evaluates,
// shifts and registers the result, and S_DONE, which registers rsp_valid to
// present it. The max request walks a running maximum down the registered
// cell row, one cell per cycle, in S_MAX before S_DONE.
// Search compares in every cell at once; the hits are ORed into match_ff.
// Shifts move cells by one place at once: up from the insert point, or down.
// busy falls with the result cycle, so the next request can be taken at the
// edge that ends it; no new request is taken while one is in progress.
// Reset clears the entry count and the controller; cell contents are not
// cleared, entries at or above the count are never used.
// The receiver cannot stall: results are presented once and dropped after.
module integer_deque_engine #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ide_pkg::REQ_W-1:0]     req_type,
   input  logic signed [ide_pkg::DATA_W-1:0] req_operand_value,
   output logic                          rsp_valid,
   output logic [ide_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [ide_pkg::DATA_W-1:0] rsp_result_value,
   output logic                          rsp_found,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count
);
   import ide_pkg::*;
   localparam int unsigned CW = $clog2(DEPTH+1);
   localparam int unsigned MW = $clog2(DEPTH+2);
   localparam int unsigned IW = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_CMP = 5'b00010, S_EVAL = 5'b00100, S_MAX = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type_type req_ff;
   logic [DATA_W-1:0] opv_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [MW-1:0] mcnt_ff, mcnt_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic found_ff, found_in, match_ff, valid_ff, valid_in;

   cell_cmd_type cmd;
   logic [CW-1:0] ins_pos;
   logic [DATA_W-1:0] vals [DEPTH];
   logic [DATA_W-1:0] maxs [DEPTH];
   logic [DEPTH-1:0] hit_vec;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] lo_v, up_v, mx_in;
      if (g == 0) begin : g_lo
         assign lo_v = '0;
         assign mx_in = '0;
      end else begin : g_lo
         assign lo_v = vals[g-1];
         assign mx_in = maxs[g-1];
      end
      if (g == DEPTH-1) begin : g_up
         assign up_v = '0;
      end else begin : g_up
         assign up_v = vals[g+1];
      end
      ide_cell u_cell (
         .clock(clock), .cmd(cmd),
         .sel_ins(CW'(g) == ins_pos),
         .up_en(CW'(g) > ins_pos && CW'(g) <= count_ff),
         .dn_en(CW'(g) + 1'b1 < count_ff),
         .live(CW'(g) < count_ff),
         .lower_val(lo_v), .upper_val(up_v), .max_in(mx_in),
         .val(vals[g]), .match(hit_vec[g]), .max_out(maxs[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      mcnt_in = mcnt_ff;
      st_in = st_ff;
      res_in = res_ff;
      found_in = found_ff;
      valid_in = 1'b0;
      cmd = '{shift_up: 1'b0, shift_down: 1'b0, value: opv_ff};
      ins_pos = '0;
      unique case (req_ff)
         REQ_PUSH_BACK: ins_pos = count_ff;
         REQ_MID_INSERT: ins_pos = count_ff >> 1;
         default: ins_pos = '0;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            st_in = ST_OK;
            res_in = '0;
            found_in = 1'b0;
            state_in = S_DONE;
            unique case (req_ff)
               REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                  if (count_ff >= CW'(DEPTH)) st_in = ST_FULL;
                  else begin
                     cmd.shift_up = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               REQ_POP_FRONT: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else begin
                     res_in = vals[0];
                     cmd.shift_down = 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end
               REQ_POP_BACK: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else begin
                     res_in = vals[IW'(count_ff - 1'b1)];
                     count_in = count_ff - 1'b1;
                  end
               end
               REQ_SEARCH: found_in = match_ff;
               REQ_MID_INSERT: begin
                  if (match_ff) st_in = ST_PRESENT;
                  else if (count_ff < CW'(2)) st_in = ST_SHORT;
                  else if (count_ff >= CW'(DEPTH)) st_in = ST_FULL;
                  else begin
                     cmd.shift_up = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               REQ_MAX: begin
                  mcnt_in = '0;
                  state_in = S_MAX;
               end
               default: ;
            endcase
         end
         S_MAX: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MW'(DEPTH)) begin
               res_in = maxs[DEPTH-1];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      mcnt_ff <= mcnt_in;
      st_ff <= st_in;
      res_ff <= res_in;
      found_ff <= found_in;
      match_ff <= |hit_vec;
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_type_type'(req_type);
         opv_ff <= req_operand_value;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_status = st_ff;
   assign rsp_result_value = res_ff;
   assign rsp_found = found_ff;
   assign rsp_entry_count = count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count above depth");
   a_valid_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held twice");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer not taken");
endmodule

[tb/sv/tb_integer_deque_engine.sv]
// Testbench for integer_deque_engine: directed and random deque requests,
// each result checked against a behavioral deque kept in the bench.
// Depends on ide_pkg and the integer_deque_engine RTL.
`timescale 1ns / 100ps

module tb_integer_deque_engine;
   import ide_pkg::*;

   localparam int unsigned DEPTH = 256;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 20 * (DEPTH + 400);

   typedef struct {
      logic [REQ_W-1:0] kind;
      logic signed [DATA_W-1:0] operand;
      int gap;
   } deque_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic signed [DATA_W-1:0] value;
      logic found;
      logic [CNT_W-1:0] count;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [REQ_W-1:0] req_type = '0;
   logic signed [DATA_W-1:0] req_operand_value = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic rsp_found;
   logic [CNT_W-1:0] rsp_entry_count;

   deque_req_type pending_reqs[$];
   deque_rsp_type expected_rsps[$];
   logic signed [DATA_W-1:0] model_list[$];
   int error_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit stim_done = 1'b0;
   logic xfer_seen = 1'b0;
   logic signed [DATA_W-1:0] used_vals[$];

   integer_deque_engine #(.DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_operand_value(req_operand_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value), .rsp_found(rsp_found),
      .rsp_entry_count(rsp_entry_count)
   );

   always #6 clock = ~clock;

   function automatic bit list_has(logic signed [DATA_W-1:0] v);
      foreach (model_list[i]) if (model_list[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   function automatic deque_rsp_type apply_deque_req(deque_req_type r);
      deque_rsp_type o;
      o.status = ST_OK;
      o.value = '0;
      o.found = 1'b0;
      case (r.kind)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (model_list.size() >= DEPTH) o.status = ST_FULL;
            else if (r.kind == REQ_PUSH_FRONT) model_list.push_front(r.operand);
            else model_list.push_back(r.operand);
         end
         REQ_POP_FRONT: begin
            if (model_list.size() == 0) o.status = ST_EMPTY;
            else o.value = model_list.pop_front();
         end
         REQ_POP_BACK: begin
            if (model_list.size() == 0) o.status = ST_EMPTY;
            else o.value = model_list.pop_back();
         end
         REQ_SEARCH: o.found = list_has(r.operand);
         REQ_MID_INSERT: begin
            if (list_has(r.operand)) o.status = ST_PRESENT;
            else if (model_list.size() < 2) o.status = ST_SHORT;
            else if (model_list.size() >= DEPTH) o.status = ST_FULL;
            else model_list.insert(model_list.size() / 2, r.operand);
         end
         REQ_MAX: foreach (model_list[i]) if (model_list[i] > o.value) o.value = model_list[i];
         default: ;
      endcase
      o.count = CNT_W'(model_list.size());
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int p;
      p = $urandom_range(0, 9);
      if (p < 4 && used_vals.size() > 0) return used_vals[$urandom_range(0, used_vals.size() - 1)];
      if (p < 6) return $signed(DATA_W'($urandom_range(0, 15)) - 8);
      return $signed($urandom());
   endfunction

   task automatic add_req(logic [REQ_W-1:0] k, logic signed [DATA_W-1:0] v, int g);
      deque_req_type r;
      r.kind = k;
      r.operand = v;
      r.gap = g;
      pending_reqs.push_back(r);
      used_vals.push_back(v);
      if (used_vals.size() > 64) void'(used_vals.pop_front());
   endtask

   initial begin
      int n;
      int mode;
      logic [REQ_W-1:0] k;
      // empty and short list corner cases
      add_req(REQ_POP_FRONT, 0, 0);
      add_req(REQ_POP_BACK, 0, 0);
      add_req(REQ_MAX, 0, 1);
      add_req(REQ_MID_INSERT, 5, 0);
      add_req(REQ_SEARCH, 5, 0);
      add_req(REQ_PUSH_FRONT, 32'sh7FFFFFFF, 0);
      add_req(REQ_MID_INSERT, 9, 2);
      add_req(REQ_PUSH_BACK, 32'sh80000000, 0);
      add_req(REQ_MID_INSERT, 32'sh7FFFFFFF, 0);
      add_req(REQ_MID_INSERT, -1, 0);
      add_req(REQ_SEARCH, 32'sh80000000, 0);
      add_req(REQ_MAX, 0, 0);
      add_req(REQ_NONE, 32'shFFFFFFFF, 3);
      add_req(REQ_POP_FRONT, 0, 0);
      add_req(REQ_POP_BACK, 0, 0);
      add_req(REQ_POP_BACK, 0, 0);
      add_req(REQ_PUSH_BACK, -7, 0);
      add_req(REQ_MAX, 0, 0);
      add_req(REQ_POP_FRONT, 0, 0);
      // fill to full, hit full cases, then drain
      for (int i = 0; i < DEPTH; i++) add_req(REQ_PUSH_BACK, $signed($urandom()), 0);
      add_req(REQ_PUSH_FRONT, 1, 0);
      add_req(REQ_PUSH_BACK, 2, 0);
      add_req(REQ_MID_INSERT, $signed($urandom()), 0);
      add_req(REQ_MAX, 0, 0);
      for (int i = 0; i < DEPTH; i++) add_req(REQ_POP_FRONT, 0, (pick_gap() > 3) ? 1 : 0);
      n = 0;
      while (n < 860) begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(5, 40)) begin
            case (mode)
               0: k = ($urandom_range(0, 9) < 6)
                      ? REQ_W'(REQ_PUSH_FRONT + $urandom_range(0, 1))
                      : REQ_W'(REQ_SEARCH + $urandom_range(0, 1));
               1: k = ($urandom_range(0, 9) < 6)
                      ? REQ_W'(REQ_POP_FRONT + $urandom_range(0, 1))
                      : REQ_SEARCH;
               default: k = REQ_W'($urandom_range(0, 7));
            endcase
            if (k == REQ_MAX && $urandom_range(0, 3) != 0) k = REQ_SEARCH;
            add_req(k, pick_value(), pick_gap());
            n++;
         end
      end
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   always @(negedge clock) begin
      deque_req_type r;
      if (!reset) begin
         if (start && xfer_seen) begin
            start <= 1'b0;
         end else if (!start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_type <= r.kind;
               req_operand_value <= r.operand;
               start <= 1'b1;
               gap_left <= r.gap;
               if (pending_reqs.size() == 0) stim_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      deque_req_type r;
      deque_rsp_type e;
      if (reset) begin
         xfer_seen <= 1'b0;
         idle_cycles <= 0;
      end else begin
         xfer_seen <= start && !busy;
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (start && !busy) begin
            r.kind = req_type;
            r.operand = req_operand_value;
            r.gap = 0;
            expected_rsps.push_back(apply_deque_req(r));
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected");
               error_count = error_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  error_count = error_count + 1;
               end
               if (rsp_result_value !== e.value) begin
                  $error("result_value expected %0d actual %0d", e.value, rsp_result_value);
                  error_count = error_count + 1;
               end
               if (rsp_found !== e.found) begin
                  $error("found expected %0d actual %0d", e.found, rsp_found);
                  error_count = error_count + 1;
               end
               if (rsp_entry_count !== e.count) begin
                  $error("entry_count expected %0d actual %0d", e.count, rsp_entry_count);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   initial begin
      wait (stim_done && !start && expected_rsps.size() == 0);
      repeat (DEPTH + 20) @(posedge clock);
      #1;
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("integer_deque_engine test passed");
      end else begin
         $display("integer_deque_engine test failed");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("integer_deque_engine test failed");
      $finish;
   end
endmodule
